// ----- src/pia_pkg.sv -----
// Shared types and constants for the process id allocator.
package pia_pkg;

  localparam int PID_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 16;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RELEASE,
    S_CHECK,
    S_INSERT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic shift;
    logic fb_valid;
  } ring_ctl_t;

endpackage

// ----- src/pia_cell.sv -----
// One slot of the id ring: a valid bit and a stored id, passed on to the neighbour.
module pia_cell #(
  parameter int ID_W = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            din_valid,
  input  logic [ID_W-1:0] din_id,
  output logic            dout_valid,
  output logic [ID_W-1:0] dout_id
);

  logic            valid;
  logic [ID_W-1:0] id;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      id <= din_id;
    end
  end

  assign dout_valid = valid;
  assign dout_id    = id;

endmodule

// ----- src/pia_ctrl.sv -----
// Request sequencer: walks the id ring for release, rescan and insert passes.
module pia_ctrl #(
  parameter int SLOTS     = 64,
  parameter int PID_LIMIT = 128,
  parameter int ID_W      = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [pia_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [pia_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                       head_valid,
  input  logic [ID_W-1:0]            head_id,
  output pia_pkg::ring_ctl_t         ring_ctl,
  output logic [ID_W-1:0]            fb_id
);
  import pia_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CMP_W = (ID_W > PID_W) ? ID_W : PID_W;
  localparam int ID_W1 = ID_W + 1;
  localparam int FULL_COUNT = (SLOTS < PID_LIMIT - 1) ? SLOTS : PID_LIMIT - 1;

  state_t              state, state_next;
  logic [IDX_W-1:0]    cnt, cnt_next;
  logic [ID_W-1:0]     cand, cand_next;
  logic [ID_W-1:0]     bnd, bnd_next;
  logic                hit, hit_next;
  logic [CMP_W-1:0]    key, key_next;
  logic [ID_W-1:0]     last_issued, last_issued_next;
  logic [ID_W-1:0]     safe_bound, safe_bound_next;
  logic [CNT_W-1:0]    live_count, live_count_next;
  logic [PID_W-1:0]    res_pid, res_pid_next;
  status_t             res_status, res_status_next;
  logic                m_tvalid_next;
  logic [M_TDATA_W-1:0] m_tdata_next;

  logic                pass_end;
  logic                match;
  logic                hit_now;
  logic [ID_W-1:0]     bnd_now;
  logic [ID_W1-1:0]    cand_up;
  logic [ID_W1-1:0]    cand_inc;
  logic [PID_W-1:0]    req_pid;

  assign req_pid  = s_tdata[PID_W-1:0];
  assign pass_end = (cnt == IDX_W'(SLOTS - 1));
  assign match    = head_valid &&
                    (CMP_W'(head_id) == ((state == S_CHECK) ? CMP_W'(cand) : key));
  assign hit_now  = hit | match;
  assign bnd_now  = (head_valid && head_id > cand && head_id < bnd) ? head_id : bnd;
  assign cand_up  = ID_W1'(last_issued) + ID_W1'(1);
  assign cand_inc = ID_W1'(cand) + ID_W1'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_issued <= ID_W'(PID_LIMIT);
      safe_bound  <= ID_W'(PID_LIMIT);
      live_count  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      last_issued <= last_issued_next;
      safe_bound  <= safe_bound_next;
      live_count  <= live_count_next;
      m_tvalid    <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    cand       <= cand_next;
    bnd        <= bnd_next;
    hit        <= hit_next;
    key        <= key_next;
    res_pid    <= res_pid_next;
    res_status <= res_status_next;
    m_tdata    <= m_tdata_next;
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    cand_next        = cand;
    bnd_next         = bnd;
    hit_next         = hit;
    key_next         = key;
    last_issued_next = last_issued;
    safe_bound_next  = safe_bound;
    live_count_next  = live_count;
    res_pid_next     = res_pid;
    res_status_next  = res_status;
    m_tvalid_next    = m_tvalid && !m_tready;
    m_tdata_next     = m_tdata;
    s_tready         = 1'b0;
    ring_ctl.shift    = 1'b0;
    ring_ctl.fb_valid = head_valid;
    fb_id             = head_id;

    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cnt_next = '0;
        hit_next = 1'b0;
        bnd_next = ID_W'(PID_LIMIT);
        if (s_tvalid) begin
          if (op_t'(s_tuser) == OP_RELEASE) begin
            key_next     = CMP_W'(req_pid);
            res_pid_next = req_pid;
            state_next   = S_RELEASE;
          end else if (live_count >= CNT_W'(FULL_COUNT)) begin
            res_pid_next    = '0;
            res_status_next = ST_FULL;
            state_next      = S_RESP;
          end else if (cand_up >= ID_W1'(PID_LIMIT)) begin
            cand_next  = ID_W'(1);
            state_next = S_CHECK;
          end else if (cand_up >= ID_W1'(safe_bound)) begin
            cand_next  = ID_W'(cand_up);
            state_next = S_CHECK;
          end else begin
            cand_next  = ID_W'(cand_up);
            state_next = S_INSERT;
          end
        end
      end
      S_RELEASE: begin
        ring_ctl.shift = 1'b1;
        cnt_next       = cnt + IDX_W'(1);
        hit_next       = hit_now;
        if (match && !hit) begin
          ring_ctl.fb_valid = 1'b0;
        end
        if (pass_end) begin
          res_status_next = hit_now ? ST_OK : ST_UNKNOWN;
          if (hit_now) begin
            live_count_next = live_count - CNT_W'(1);
          end
          state_next = S_RESP;
        end
      end
      S_CHECK: begin
        ring_ctl.shift = 1'b1;
        cnt_next       = cnt + IDX_W'(1);
        hit_next       = hit_now;
        bnd_next       = bnd_now;
        if (pass_end) begin
          hit_next = 1'b0;
          cnt_next = '0;
          if (hit_now) begin
            cand_next = (cand_inc >= ID_W1'(PID_LIMIT)) ? ID_W'(1) : ID_W'(cand_inc);
            bnd_next  = ID_W'(PID_LIMIT);
          end else begin
            safe_bound_next = bnd_now;
            state_next      = S_INSERT;
          end
        end
      end
      S_INSERT: begin
        ring_ctl.shift = 1'b1;
        cnt_next       = cnt + IDX_W'(1);
        if (!head_valid && !hit) begin
          ring_ctl.fb_valid = 1'b1;
          fb_id             = cand;
          hit_next          = 1'b1;
        end
        if (pass_end) begin
          last_issued_next = cand;
          live_count_next  = live_count + CNT_W'(1);
          res_pid_next     = PID_W'(cand);
          res_status_next  = ST_OK;
          state_next       = S_RESP;
        end
      end
      S_RESP: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = M_TDATA_W'({res_status, res_pid});
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/process_id_allocator_unit.sv -----
// Process id allocator: one request at a time over a rotating ring of SLOTS id cells.
// A full table is answered without a ring pass; release or allocate without rescan takes one ring pass;
// allocate with rescan takes one check pass per candidate tried, then one insert pass.
// One request in flight; each ring pass visits all SLOTS cells, one cell a cycle.
// Reset clears every cell valid bit, the live count and the output valid;
// last issued id and safe bound restart at PID_LIMIT.
module process_id_allocator_unit #(
  parameter int SLOTS     = 64,
  parameter int PID_LIMIT = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pia_pkg::S_TDATA_W-1:0] s_tdata,  // [6:0] pid, [7] zero
  input  logic                          s_tuser,  // [0] operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pia_pkg::M_TDATA_W-1:0] m_tdata   // [6:0] pid_res, [8:7] status, [15:9] zero
);
  import pia_pkg::*;

  localparam int ID_W = $clog2(PID_LIMIT + 1);

  ring_ctl_t             ring_ctl;
  logic [ID_W-1:0]       fb_id;
  logic [SLOTS-1:0]      ring_valid;
  logic [ID_W-1:0]       ring_id [SLOTS];

  pia_ctrl #(
    .SLOTS     (SLOTS),
    .PID_LIMIT (PID_LIMIT),
    .ID_W      (ID_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .head_valid (ring_valid[0]),
    .head_id    (ring_id[0]),
    .ring_ctl   (ring_ctl),
    .fb_id      (fb_id)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      pia_cell #(.ID_W(ID_W)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (ring_ctl.shift),
        .din_valid  (ring_ctl.fb_valid),
        .din_id     (fb_id),
        .dout_valid (ring_valid[i]),
        .dout_id    (ring_id[i])
      );
    end else begin : g_body
      pia_cell #(.ID_W(ID_W)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (ring_ctl.shift),
        .din_valid  (ring_valid[i+1]),
        .din_id     (ring_id[i+1]),
        .dout_valid (ring_valid[i]),
        .dout_id    (ring_id[i])
      );
    end
  end

`ifndef SYNTH
  a_idle_ring_still: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !ring_ctl.shift)
    else $error("ring moves while requests are taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken before the first completes");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready && !ring_ctl.shift))
    else $error("reset did not clear output and sequencer");
`endif

endmodule

// ----- test/tb_process_id_allocator_unit.sv -----
// Testbench for the process id allocator: random allocate and release requests checked against a shadow id table.
`timescale 1ns / 100ps
module tb_process_id_allocator_unit;
  import pia_pkg::*;

  localparam int SLOTS     = 64;
  localparam int PID_LIMIT = 128;
  localparam int N_RANDOM  = 1500;
  localparam int MAX_WAIT  = 18;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_RELEASE_ANY,
    KIND_RELEASE_LIVE
  } req_kind_t;

  typedef struct {
    req_kind_t        kind;
    logic [PID_W-1:0] pid;
  } pid_req_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    status_t          status;
  } pid_reply_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // shadow id table
  logic             live_slot [SLOTS];
  logic [PID_W-1:0] slot_pid  [SLOTS];
  logic [7:0]       prev_issued;
  logic [7:0]       pid_bound;
  logic [6:0]       live_total;

  pid_req_t         req_backlog [$];
  pid_reply_t       replies_due [$];
  pid_req_t         nxt_req;
  op_t              cur_op;
  logic [PID_W-1:0] cur_pid;
  bit               presenting = 1'b0;
  int               send_gap, send_calm;
  int               recv_wait, recv_calm;
  int               mismatches = 0;
  pid_reply_t       want;

  process_id_allocator_unit #(
    .SLOTS    (SLOTS),
    .PID_LIMIT(PID_LIMIT)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit pid_in_use(int id);
    for (int i = 0; i < SLOTS; i++)
      if (live_slot[i] && slot_pid[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int lowest_live_above(int id);
    int b;
    b = PID_LIMIT;
    for (int i = 0; i < SLOTS; i++)
      if (live_slot[i] && slot_pid[i] > id && slot_pid[i] < b) b = slot_pid[i];
    return b;
  endfunction

  function automatic pid_reply_t apply_pid_request(op_t op, logic [PID_W-1:0] pid);
    pid_reply_t r;
    int         cand;
    bit         rescan;
    r.pid    = pid;
    r.status = ST_UNKNOWN;
    if (op == OP_ALLOC) begin
      if (live_total >= SLOTS || live_total >= PID_LIMIT - 1) begin
        r.pid    = '0;
        r.status = ST_FULL;
        return r;
      end
      cand   = prev_issued + 1;
      rescan = 1'b0;
      if (cand >= PID_LIMIT) begin
        cand   = 1;
        rescan = 1'b1;
      end else if (cand >= pid_bound) begin
        rescan = 1'b1;
      end
      if (rescan) begin
        // skip ids in use, wrapping back to 1
        while (pid_in_use(cand)) begin
          cand++;
          if (cand >= PID_LIMIT) cand = 1;
        end
        pid_bound = 8'(lowest_live_above(cand));
      end
      prev_issued = 8'(cand);
      for (int i = 0; i < SLOTS; i++) begin
        if (!live_slot[i]) begin
          live_slot[i] = 1'b1;
          slot_pid[i]  = cand[PID_W-1:0];
          break;
        end
      end
      live_total++;
      r.pid    = cand[PID_W-1:0];
      r.status = ST_OK;
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (live_slot[i] && slot_pid[i] == pid) begin
        live_slot[i] = 1'b0;
        if (live_total > 0) live_total--;
        r.status = ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  function automatic logic [PID_W-1:0] choose_live_pid();
    int k;
    if (live_total == 0) return PID_W'($urandom_range(0, PID_LIMIT - 1));
    k = $urandom_range(0, live_total - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (live_slot[i]) begin
        if (k == 0) return slot_pid[i];
        k--;
      end
    end
    return '0;
  endfunction

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 40);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic queue_req(req_kind_t kind, int pid);
    pid_req_t q;
    q.kind = kind;
    q.pid  = PID_W'(pid);
    req_backlog.push_back(q);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      presenting = 1'b0;
      send_gap   = 0;
      send_calm  = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        replies_due.push_back(apply_pid_request(cur_op, cur_pid));
        presenting = 1'b0;
        send_gap   = draw_wait(send_calm);
      end
      if (!presenting && send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (!presenting && req_backlog.size() != 0) begin
        nxt_req = req_backlog.pop_front();
        cur_op  = (nxt_req.kind == KIND_ALLOC) ? OP_ALLOC : OP_RELEASE;
        // pick a live id against the table as it stands now
        cur_pid = (nxt_req.kind == KIND_RELEASE_LIVE) ? choose_live_pid() : nxt_req.pid;
        s_tvalid  <= 1'b1;
        s_tdata   <= {1'b0, cur_pid};
        s_tuser   <= cur_op;
        presenting = 1'b1;
      end else if (!presenting) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = 0;
      recv_calm = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected reply pid %0d status %0d",
                                    m_tdata[PID_W-1:0], m_tdata[PID_W+STATUS_W-1:PID_W]));
        end else begin
          want = replies_due.pop_front();
          if (m_tdata[PID_W-1:0] !== want.pid)
            report_mismatch($sformatf("pid_res %0d, expected %0d",
                                      m_tdata[PID_W-1:0], want.pid));
          if (m_tdata[PID_W+STATUS_W-1:PID_W] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_tdata[PID_W+STATUS_W-1:PID_W], want.status));
        end
        recv_wait = draw_wait(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int issued;
    int run_len;
    int alloc_pct;
    int phase;
    for (int i = 0; i < SLOTS; i++) begin
      live_slot[i] = 1'b0;
      slot_pid[i]  = '0;
    end
    prev_issued = 8'(PID_LIMIT);
    pid_bound   = 8'(PID_LIMIT);
    live_total  = '0;
    issued      = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_ALLOC, 127);
    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_RELEASE_ANY, 2);
    queue_req(KIND_RELEASE_ANY, 2);
    queue_req(KIND_RELEASE_ANY, 0);
    queue_req(KIND_RELEASE_ANY, 127);
    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_RELEASE_LIVE, 0);
    queue_req(KIND_RELEASE_ANY, 'h55);
    queue_req(KIND_RELEASE_ANY, 'h2A);
    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_ALLOC, 0);

    // runs biased to fill, drain or churn the table
    while (issued < N_RANDOM) begin
      phase     = $urandom_range(0, 2);
      run_len   = $urandom_range(20, 120);
      alloc_pct = (phase == 0) ? 90 : (phase == 1) ? 20 : 55;
      repeat (run_len) begin
        if ($urandom_range(1, 100) <= alloc_pct)
          queue_req(KIND_ALLOC, $urandom_range(0, PID_LIMIT - 1));
        else if ($urandom_range(0, 6) == 0)
          queue_req(KIND_RELEASE_ANY, $urandom_range(0, PID_LIMIT - 1));
        else
          queue_req(KIND_RELEASE_LIVE, 0);
        issued++;
      end
    end

    while (req_backlog.size() != 0 || presenting || replies_due.size() != 0)
      @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);

    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pia_pkg.sv
src/pia_cell.sv
src/pia_ctrl.sv
src/process_id_allocator_unit.sv
test/tb_process_id_allocator_unit.sv
